### hw/rtl/elcr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the echo level change reporter.
// No dependencies; every other file imports this package.
package elcr_pkg;

  // Field widths
  localparam int ECHO_W     = 15;
  localparam int TIME_W     = 32;
  localparam int DIST_W     = 10;
  localparam int CM_W       = 9;
  localparam int PCT_W      = 7;
  localparam int CHG_W      = 8;
  localparam int LVL_W      = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Shared divider sizing (level mapping)
  localparam int LVL_NUM_W = 16;  // |(d - e) * 100| <= 51200
  localparam int DIV_NUM_W = LVL_NUM_W;
  localparam int DIV_DEN_W = 10;  // holds any span magnitude
  localparam int DIV_CNT_W = 5;
  localparam int ITER_LEVEL = LVL_NUM_W;

  // Distance: floor(echo_us * 17 / 1000) = (echo_us * ceil(17 * 2^25 / 1000)) >> 25,
  // exact for every 15-bit echo width
  localparam int DIST_RECIP_W  = 20;
  localparam int DIST_RECIP_SH = 25;
  localparam int DIST_PROD_W   = ECHO_W + DIST_RECIP_W;
  localparam int DIST_QUO_W    = DIST_PROD_W - DIST_RECIP_SH;
  localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = 20'd570426;

  localparam logic [CM_W-1:0]      DIST_MAX    = CM_W'(511);
  localparam logic [PCT_W-1:0]     PCT_MAX     = PCT_W'(100);
  localparam logic [LVL_W-1:0]     LAST_LVL_RST = 8'h9C;  // -100

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CM    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_CM     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANGE  = 8'd3;

  // Register reset values
  localparam logic [CM_W-1:0]   EMPTY_CM_RST    = 9'd30;
  localparam logic [CM_W-1:0]   FULL_CM_RST     = 9'd5;
  localparam logic [TIME_W-1:0] INTERVAL_MS_RST = 32'd60000;
  localparam logic [CHG_W-1:0]  MIN_CHANGE_RST  = 8'd5;

  typedef struct packed {
    logic [CM_W-1:0]   empty_distance_cm;
    logic [CM_W-1:0]   full_distance_cm;
    logic [TIME_W-1:0] report_interval_ms;
    logic [CHG_W-1:0]  min_change_pct;
  } elcr_cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] iters;
  } elcr_div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } elcr_div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_PREP,
    ST_LEVEL,
    ST_DECIDE
  } elcr_state_t;

endpackage

### hw/rtl/elcr_in_if.sv
`timescale 1ns / 1ps
// Input reading channel: valid/ready plus one reading.
// Depends on elcr_pkg for field widths.
interface elcr_in_if;
  import elcr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ECHO_W-1:0] echo_us;
  logic [TIME_W-1:0] now_ms;
  logic              link_up;
  logic              send_ok;

  modport source (output valid, echo_us, now_ms, link_up, send_ok, input ready);
  modport sink   (input valid, echo_us, now_ms, link_up, send_ok, output ready);
endinterface

### hw/rtl/elcr_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready plus one result.
// Depends on elcr_pkg for field widths.
interface elcr_out_if;
  import elcr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] distance_cm;
  logic [PCT_W-1:0]         level_pct;
  logic                     report_due;
  logic                     reported;

  modport source (output valid, distance_cm, level_pct, report_due, reported,
                  input ready);
  modport sink   (input valid, distance_cm, level_pct, report_due, reported,
                  output ready);
endinterface

### hw/rtl/elcr_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready, register index and data.
// Depends on elcr_pkg for widths.
interface elcr_cfg_if;
  import elcr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/elcr_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on elcr_pkg (request/response structs, widths).
module elcr_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  elcr_pkg::elcr_div_req_t req,
  output elcr_pkg::elcr_div_rsp_t rsp
);
  import elcr_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 last_step;

  assign last_step = busy_r && (cnt_r == DIV_CNT_W'(1));

  // Trial subtract of the shifted partial remainder; top bit set means borrow.
  always_comb begin
    trial = {rem_r, quo_r[DIV_NUM_W-1]} - {1'b0, den_r};
    if (!trial[DIV_DEN_W]) begin
      rem_nxt = trial[DIV_DEN_W-1:0];
      quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[DIV_DEN_W-2:0], quo_r[DIV_NUM_W-1]};
      quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last_step;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (last_step) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      den_r <= req.divisor;
      cnt_r <= req.iters;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider busy with zero count");

endmodule

### hw/rtl/elcr_cfg.sv
`timescale 1ns / 1ps
// Configuration register bank, written over the cfg channel.
// Depends on elcr_pkg and elcr_cfg_if.
module elcr_cfg (
  input  logic                clk,
  input  logic                rst_n,
  elcr_cfg_if.sink            cfg_ch,
  output elcr_pkg::elcr_cfg_t cfg
);
  import elcr_pkg::*;

  elcr_cfg_t cfg_r;
  logic      wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid;  // always ready
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.empty_distance_cm  <= EMPTY_CM_RST;
      cfg_r.full_distance_cm   <= FULL_CM_RST;
      cfg_r.report_interval_ms <= INTERVAL_MS_RST;
      cfg_r.min_change_pct     <= MIN_CHANGE_RST;
    end else if (wr) begin
      unique case (cfg_ch.index)
        REG_EMPTY_CM:    cfg_r.empty_distance_cm  <= cfg_ch.data[CM_W-1:0];
        REG_FULL_CM:     cfg_r.full_distance_cm   <= cfg_ch.data[CM_W-1:0];
        REG_INTERVAL_MS: cfg_r.report_interval_ms <= cfg_ch.data[TIME_W-1:0];
        REG_MIN_CHANGE:  cfg_r.min_change_pct     <= cfg_ch.data[CHG_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

endmodule

### hw/rtl/echo_level_change_reporter_top.sv
`timescale 1ns / 1ps
// Top level of the echo level change reporter: sequencer, datapath, output register.
// Depends on elcr_pkg, the channel interfaces, elcr_cfg and elcr_div.

// One reading in, one result out. The echo width becomes a distance
// floor(echo_us*17/1000) cm (saturated at 511, -1 on a zero-width timeout),
// the distance is mapped onto 0..100 percent between the empty and full
// distances (truncating division, then clamped; 0 when the two are equal),
// and a report is flagged when the report interval has elapsed or the level
// moved by at least min_change_pct since the last report. When the report is
// due, the link is up and the send is accepted, the reading's time and level
// become the new reference. After the accept beat a reading passes through
// these steps in order: the distance (a multiply by a fixed reciprocal of
// 1000/17), the set-up of the level division, 16 quotient bits one per
// cycle through a single shared restoring divider, the clamp, and the load
// of the output register. in_ch.ready is high only while the sequencer is
// idle; no reading is taken until the last one has left it. The result sits
// in an output register, so the next reading may be accepted while the
// previous result waits to be taken; a reading that finishes while the
// output register is still full holds in its last step until it frees.
// Configuration writes are taken at any time (cfg_ch.ready is tied high) but
// should only be issued while no reading is in flight.
module echo_level_change_reporter_top (
  input logic       clk,
  input logic       rst_n,
  elcr_in_if.sink   in_ch,
  elcr_out_if.source out_ch,
  elcr_cfg_if.sink  cfg_ch
);
  import elcr_pkg::*;

  elcr_cfg_t     cfg;
  elcr_div_req_t div_req;
  elcr_div_rsp_t div_rsp;

  elcr_state_t state_r, state_nxt;

  // Reading captured at the accept beat
  logic              echo_zero_r;
  logic [ECHO_W-1:0] echo_r;
  logic [TIME_W-1:0] now_r;
  logic              link_r;
  logic              send_r;

  // Intermediate results
  logic signed [DIST_W-1:0] dist_r;
  logic                     neg_r;
  logic [PCT_W-1:0]         pct_r;

  // Reference of the last report
  logic [TIME_W-1:0] last_time_r;
  logic [LVL_W-1:0]  last_lvl_r;

  // Output register
  logic                     out_valid_r;
  logic signed [DIST_W-1:0] out_dist_r;
  logic [PCT_W-1:0]         out_pct_r;
  logic                     out_due_r;
  logic                     out_rep_r;

  logic in_acc;
  logic out_free;
  logic load_out;

  elcr_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  elcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign load_out    = (state_r == ST_DECIDE) && out_free;

  // ---- distance: echo_us * 17 / 1000 by reciprocal multiply and shift
  logic [DIST_PROD_W-1:0] dist_prod;
  logic [DIST_QUO_W-1:0]  dist_quo;
  assign dist_prod = DIST_PROD_W'(echo_r) * DIST_PROD_W'(DIST_RECIP);
  assign dist_quo  = dist_prod[DIST_PROD_W-1:DIST_RECIP_SH];

  logic signed [DIST_W-1:0] dist_nxt;
  always_comb begin
    if (echo_zero_r) begin
      dist_nxt = -DIST_W'(1);
    end else if (dist_quo > DIST_QUO_W'(DIST_MAX)) begin
      dist_nxt = DIST_W'(DIST_MAX);
    end else begin
      dist_nxt = DIST_W'(dist_quo);
    end
  end

  // ---- level numerator (d - e) * 100 and span f - e, as sign + magnitude
  logic signed [DIST_W:0]   delta;
  logic signed [17:0]       prod;
  logic [LVL_NUM_W-1:0]     num_mag;
  logic signed [CM_W:0]     span;
  logic [CM_W-1:0]          span_mag;
  logic                     span_zero;

  always_comb begin
    delta    = $signed({dist_r[DIST_W-1], dist_r})
             - $signed({2'b00, cfg.empty_distance_cm});
    prod     = 18'(delta) * 18'sd100;
    num_mag  = prod[17] ? LVL_NUM_W'(-prod) : LVL_NUM_W'(prod);
    span     = $signed({1'b0, cfg.full_distance_cm})
             - $signed({1'b0, cfg.empty_distance_cm});
    span_mag = span[CM_W] ? CM_W'(-span) : CM_W'(span);
    span_zero = (span == '0);
  end

  // ---- clamp of the level quotient; a negative quotient or a zero span reads as 0
  logic [PCT_W-1:0] pct_nxt;
  always_comb begin
    if (span_zero || neg_r) begin
      pct_nxt = '0;
    end else if (div_rsp.quotient > DIV_NUM_W'(PCT_MAX)) begin
      pct_nxt = PCT_MAX;
    end else begin
      pct_nxt = PCT_W'(div_rsp.quotient);
    end
  end

  // ---- report decision
  logic signed [LVL_W:0] lvl_diff;
  logic [LVL_W-1:0]      lvl_abs;
  logic [TIME_W-1:0]     elapsed;
  logic                  due;
  logic                  rep;

  always_comb begin
    lvl_diff = $signed({2'b00, pct_r}) - $signed({last_lvl_r[LVL_W-1], last_lvl_r});
    lvl_abs  = lvl_diff[LVL_W] ? LVL_W'(-lvl_diff) : LVL_W'(lvl_diff);
    elapsed  = now_r - last_time_r;
    due      = (elapsed >= cfg.report_interval_ms) || (lvl_abs >= cfg.min_change_pct);
    rep      = due && link_r && send_r;
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = num_mag;
    div_req.divisor  = DIV_DEN_W'(span_mag);
    div_req.iters    = DIV_CNT_W'(ITER_LEVEL);
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_DIST;
      end
      ST_DIST: begin
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        div_req.start = 1'b1;
        state_nxt     = ST_LEVEL;
      end
      ST_LEVEL: begin
        if (div_rsp.done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      echo_zero_r <= (in_ch.echo_us == '0);
      echo_r      <= in_ch.echo_us;
      now_r       <= in_ch.now_ms;
      link_r      <= in_ch.link_up;
      send_r      <= in_ch.send_ok;
    end
    if (state_r == ST_DIST) dist_r <= dist_nxt;
    if (state_r == ST_PREP) neg_r <= prod[17] ^ span[CM_W];
    if (state_r == ST_LEVEL && div_rsp.done) pct_r <= pct_nxt;
    if (load_out) begin
      out_dist_r <= dist_r;
      out_pct_r  <= pct_r;
      out_due_r  <= due;
      out_rep_r  <= rep;
    end
  end

  // Last-report reference, updated only on a successful report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      last_lvl_r  <= LAST_LVL_RST;
    end else if (load_out && rep) begin
      last_time_r <= now_r;
      last_lvl_r  <= LVL_W'(pct_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.distance_cm = out_dist_r;
  assign out_ch.level_pct   = out_pct_r;
  assign out_ch.report_due  = out_due_r;
  assign out_ch.reported    = out_rep_r;

  a_prep_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PREP) |=> div_rsp.busy)
    else $error("level setup did not start the divider");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r <= PCT_MAX))
    else $error("level above 100 percent");

  a_rep_needs_due: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rep_r) |-> out_due_r)
    else $error("reported without report due");

  a_ref_on_report: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && rep) |=> (last_lvl_r == LVL_W'(out_pct_r)))
    else $error("reference level not taken from reported level");

endmodule

### tb/elcr_level_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the echo level change reporter: predicts each result beat and checks it.
// Depends on elcr_pkg and the elcr_in_if / elcr_out_if / elcr_cfg_if channel interfaces.
module elcr_level_checker (
  input  logic clk,
  input  logic rst_n,
  elcr_in_if   in_ch,
  elcr_out_if  out_ch,
  elcr_cfg_if  cfg_ch,
  output int   fail_count,
  output int   outstanding
);
  import elcr_pkg::*;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance_cm;
    logic [PCT_W-1:0]         level_pct;
    logic                     report_due;
    logic                     reported;
  } level_report_t;

  elcr_cfg_t         regs;
  logic [TIME_W-1:0] last_time;
  int                last_level;
  level_report_t     expected_reports[$];

  // Distance, level and report decision for one reading; commits a sent report.
  function automatic level_report_t predict_report(input logic [ECHO_W-1:0] echo,
                                                   input logic [TIME_W-1:0] now,
                                                   input logic link, input logic sok);
    level_report_t     r;
    int                dist_cm;
    int                span;
    int                pct;
    int                delta;
    logic [TIME_W-1:0] elapsed;
    logic              due;
    if (echo == '0) begin
      dist_cm = -1;
    end else begin
      dist_cm = (int'(echo) * 17) / 1000;
      if (dist_cm > int'(DIST_MAX)) dist_cm = int'(DIST_MAX);
    end
    span = int'(regs.full_distance_cm) - int'(regs.empty_distance_cm);
    if (span == 0) begin
      pct = 0;
    end else begin
      pct = ((dist_cm - int'(regs.empty_distance_cm)) * 100) / span;
      if (pct < 0) pct = 0;
      if (pct > int'(PCT_MAX)) pct = int'(PCT_MAX);
    end
    delta = pct - last_level;
    if (delta < 0) delta = -delta;
    elapsed = now - last_time;
    due = (elapsed >= regs.report_interval_ms) || (delta >= int'(regs.min_change_pct));
    r.distance_cm = dist_cm[DIST_W-1:0];
    r.level_pct   = pct[PCT_W-1:0];
    r.report_due  = due;
    r.reported    = due && link && sok;
    if (r.reported) begin
      last_time  = now;
      last_level = pct;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    level_report_t want;
    if (!rst_n) begin
      regs.empty_distance_cm  = EMPTY_CM_RST;
      regs.full_distance_cm   = FULL_CM_RST;
      regs.report_interval_ms = INTERVAL_MS_RST;
      regs.min_change_pct     = MIN_CHANGE_RST;
      last_time  = '0;
      last_level = -100;
      expected_reports.delete();
      fail_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_EMPTY_CM:    regs.empty_distance_cm  = cfg_ch.data[CM_W-1:0];
          REG_FULL_CM:     regs.full_distance_cm   = cfg_ch.data[CM_W-1:0];
          REG_INTERVAL_MS: regs.report_interval_ms = cfg_ch.data[TIME_W-1:0];
          REG_MIN_CHANGE:  regs.min_change_pct     = cfg_ch.data[CHG_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with no reading pending");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_ch.distance_cm !== want.distance_cm) begin
            $error("distance_cm: expected %0d, got %0d",
                   $signed(want.distance_cm), $signed(out_ch.distance_cm));
            fail_count++;
          end
          if (out_ch.level_pct !== want.level_pct) begin
            $error("level_pct: expected %0d, got %0d", want.level_pct, out_ch.level_pct);
            fail_count++;
          end
          if (out_ch.report_due !== want.report_due) begin
            $error("report_due: expected %0b, got %0b", want.report_due, out_ch.report_due);
            fail_count++;
          end
          if (out_ch.reported !== want.reported) begin
            $error("reported: expected %0b, got %0b", want.reported, out_ch.reported);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_reports.push_back(predict_report(in_ch.echo_us, in_ch.now_ms,
                                                  in_ch.link_up, in_ch.send_ok));
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

### tb/tb_echo_level_change_reporter_top.sv
`timescale 1ns / 1ps
// Testbench top for the echo level change reporter: clock, reset, stimulus and verdict.
// Depends on elcr_pkg, the channel interfaces, the block itself and elcr_level_checker.
module tb_echo_level_change_reporter_top;
  import elcr_pkg::*;

  // Index with no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;

  // Percent chance per cycle that the sender holds off / the receiver stalls
  int in_gap_pct    = 12;
  int out_stall_pct = 61;

  // Shadow of the settings, only used to steer the random readings
  logic [CM_W-1:0]   cur_empty;
  logic [CM_W-1:0]   cur_full;
  logic [TIME_W-1:0] cur_interval;

  // Simulated tank: wall clock in ms and a slowly drifting distance
  logic [TIME_W-1:0] clock_ms;
  int                walk_cm;

  elcr_in_if  in_ch ();
  elcr_out_if out_ch ();
  elcr_cfg_if cfg_ch ();

  echo_level_change_reporter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  elcr_level_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop; a correct run ends well before this
  initial begin
    #2_000_000;
    $display("tb_echo_level_change_reporter_top: FAIL");
    $finish;
  end

  // Result side: random back-pressure, one ready update per edge
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && ($urandom_range(99) >= out_stall_pct);
    end
  end

  // One reading beat. valid is left high after the beat so that a following
  // reading never lowers and raises it in the same step; gaps lower it.
  task automatic send_reading(input logic [ECHO_W-1:0] echo, input logic [TIME_W-1:0] now,
                              input logic link, input logic sok);
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.echo_us <= echo;
    in_ch.now_ms  <= now;
    in_ch.link_up <= link;
    in_ch.send_ok <= sok;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait until every result has been taken, then let the
  // block settle for longer than one reading takes.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (48) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_EMPTY_CM:    cur_empty    = val[CM_W-1:0];
      REG_FULL_CM:     cur_full     = val[CM_W-1:0];
      REG_INTERVAL_MS: cur_interval = val;
      default: ;
    endcase
  endtask

  // Full register set while idle. Junk above the 9-bit and 8-bit fields checks
  // that the block masks the data; a stray write to an unmapped index rides along.
  task automatic apply_config(input logic [CM_W-1:0] e, input logic [CM_W-1:0] f,
                              input logic [TIME_W-1:0] ivl, input logic [CHG_W-1:0] chg);
    wait_idle();
    write_reg(REG_EMPTY_CM, ($urandom() & 32'hFFFF_FE00) | 32'(e));
    write_reg(REG_FULL_CM, ($urandom() & 32'hFFFF_FE00) | 32'(f));
    write_reg(REG_INTERVAL_MS, ivl);
    write_reg(REG_MIN_CHANGE, ($urandom() & 32'hFFFF_FF00) | 32'(chg));
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_MIN_CHANGE) + 1, 255)), $urandom());
  endtask

  // Mostly a plausible tank: time steps up to 1.5 report intervals (4000 ms if
  // 0 or over 4000) and the distance drifts between the two calibration points.
  // The rest is noise: clock jumps, timeouts, any width, over-range echoes.
  task automatic send_walk_reading();
    int                lo;
    int                hi;
    int                span_ms;
    int                roll;
    logic [ECHO_W-1:0] echo;
    lo = (cur_empty < cur_full) ? int'(cur_empty) : int'(cur_full);
    hi = (cur_empty < cur_full) ? int'(cur_full) : int'(cur_empty);
    span_ms = (cur_interval == '0 || cur_interval > 32'd4000) ? 4000 : int'(cur_interval);
    roll = $urandom_range(99);
    if (roll < 3) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, span_ms * 3 / 2);
    roll = $urandom_range(99);
    if (roll < 10) walk_cm = $urandom_range(lo, hi);
    else walk_cm = walk_cm + int'($urandom_range(0, 8)) - 4;
    if (walk_cm < lo - 10) walk_cm = lo - 10;
    if (walk_cm > hi + 10) walk_cm = hi + 10;
    if (walk_cm < 0) walk_cm = 0;
    if (walk_cm > int'(DIST_MAX)) walk_cm = int'(DIST_MAX);
    echo = ECHO_W'((walk_cm * 1000 + 16) / 17 + $urandom_range(0, 58));
    roll = $urandom_range(99);
    if (roll < 5) echo = '0;
    else if (roll < 10) echo = ECHO_W'($urandom_range(0, (1 << ECHO_W) - 1));
    else if (roll < 13) echo = ECHO_W'($urandom_range(30001, (1 << ECHO_W) - 1));
    send_reading(echo, clock_ms, $urandom_range(99) < 85, $urandom_range(99) < 85);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.echo_us <= '0;
    in_ch.now_ms  <= '0;
    in_ch.link_up <= 1'b0;
    in_ch.send_ok <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    cur_empty    = EMPTY_CM_RST;
    cur_full     = FULL_CM_RST;
    cur_interval = INTERVAL_MS_RST;
    clock_ms     = '0;
    walk_cm      = 20;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- Directed, reset settings: empty 30 cm, full 5 cm, 60 s, 5 % ---
    // Timeout: -1 cm maps past full and clamps to 100 %; first report after reset
    send_reading('0, 32'd0, 1'b1, 1'b1);
    // 0 cm, level unchanged and interval not yet elapsed: nothing due
    send_reading(15'd1, 32'd10, 1'b1, 1'b1);
    // Exactly the empty distance, big change but link down
    send_reading(15'd1765, 32'd59_999, 1'b0, 1'b1);
    // Exactly the full distance; due on the interval alone, send refused
    send_reading(15'd295, 32'd60_000, 1'b1, 1'b0);
    // Mid level, reported
    send_reading(15'd1000, 32'd60_010, 1'b1, 1'b1);
    // Top of the nominal echo range, clock near wrap
    send_reading(15'd30000, 32'hFFFF_FFF0, 1'b1, 1'b1);
    // Long echo saturates at 511 cm; elapsed wraps through zero
    send_reading(15'h7FFF, 32'h0000_0005, 1'b1, 1'b1);
    // Alternating bit patterns on every field
    send_reading(15'h5555, 32'hAAAA_AAAA, 1'b0, 1'b0);
    send_reading(15'h2AAA, 32'h5555_5555, 1'b1, 1'b1);
    send_reading(15'd1060, 32'h5555_6000, 1'b1, 1'b1);

    // Write to an unmapped index must change nothing
    wait_idle();
    write_reg(REG_UNMAPPED, 32'h0000_0001);
    send_reading(15'd1000, 32'h5555_6001, 1'b1, 1'b1);

    // Equal calibration distances: level is always 0
    apply_config(9'd100, 9'd100, 32'd60_000, 8'd5);
    send_reading('0, 32'h6000_0000, 1'b1, 1'b1);
    send_reading(15'd5882, 32'h6000_0001, 1'b1, 1'b1);
    send_reading(15'h7FFF, 32'h6000_0002, 1'b1, 1'b1);

    // Widest reversed span, zero interval and zero threshold: always due
    apply_config(9'd511, 9'd0, 32'd0, 8'd0);
    send_reading('0, 32'd7, 1'b1, 1'b1);
    send_reading(15'h7FFF, 32'd7, 1'b1, 1'b1);
    send_reading(15'd15000, 32'd8, 1'b0, 1'b1);

    // Widest forward span, longest interval, largest threshold: never due here
    apply_config(9'd0, 9'd511, 32'hFFFF_FFFF, 8'hFF);
    send_reading('0, 32'd100, 1'b1, 1'b1);
    send_reading(15'h7FFF, 32'd99, 1'b1, 1'b1);
    send_reading(15'd15000, 32'hFFFF_FFFF, 1'b1, 1'b1);

    // --- Random: seven segments of ~100 readings, each with fresh settings ---
    for (int seg = 0; seg < 7; seg++) begin
      if (seg == 3) begin
        in_gap_pct    = 61;
        out_stall_pct = 12;
      end
      if (seg == 5) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end
      case (seg % 4)
        0: apply_config(EMPTY_CM_RST, FULL_CM_RST, INTERVAL_MS_RST, MIN_CHANGE_RST);
        1: apply_config(CM_W'($urandom_range(0, 511)), CM_W'($urandom_range(0, 511)),
                        $urandom_range(0, 5000), CHG_W'($urandom_range(0, 40)));
        2: apply_config(CM_W'($urandom_range(100, 511)), CM_W'($urandom_range(0, 60)),
                        $urandom_range(0, 500), CHG_W'($urandom_range(0, 255)));
        default: apply_config(CM_W'($urandom_range(0, 20)), CM_W'($urandom_range(400, 511)),
                              $urandom(), CHG_W'($urandom_range(0, 15)));
      endcase
      walk_cm = (int'(cur_empty) + int'(cur_full)) / 2;
      repeat (100) send_walk_reading();
    end

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_echo_level_change_reporter_top: PASS");
    end else begin
      $display("tb_echo_level_change_reporter_top: FAIL");
    end
    $finish;
  end

endmodule
